// ----- rtl/hex_record_memory_loader_assert.svh -----
// Assertion macros shared by the hex record loader RTL.
// Depends on nothing; each file that uses it supplies clk and rst.
`ifndef HEX_RECORD_MEMORY_LOADER_ASSERT_SVH
`define HEX_RECORD_MEMORY_LOADER_ASSERT_SVH

// Checked at every rising edge outside reset.
`define HRML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define HRML_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hrml_pkg.sv -----
// Shared types, constants and the hex digit decoder for the hex record loader.
// Depends on nothing.
`default_nettype none

package hrml_pkg;

  localparam int AddrBits = 16;

  localparam logic [7:0] ColonChar = 8'h3A;
  localparam logic [7:0] LineFeed  = 8'd10;
  localparam logic [7:0] CaseBit   = 8'h20;

  // record types
  localparam logic [7:0] DataRecord = 8'h00;
  localparam logic [7:0] EndRecord  = 8'h01;

  // what a non-hex character decodes to
  localparam logic [7:0] BadDigit = 8'hFF;

  localparam logic [1:0] StatusLoading = 2'd0;
  localparam logic [1:0] StatusDone    = 2'd1;
  localparam logic [1:0] StatusError   = 2'd2;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  status;
  } result_t;

  // '0'..'9' -> 0..9, 'a'..'f' / 'A'..'F' -> 10..15, anything else -> 0xFF
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CaseBit;
    if (c inside {[8'h30:8'h39]}) begin
      return c - 8'h30;
    end else if (lc inside {[8'h61:8'h66]}) begin
      return lc - 8'h57;
    end
    return BadDigit;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hrml_parser.sv -----
// Record parser: phase register, field assembly and the write it produces.
// Depends on hrml_pkg and the assertion macro header.
`default_nettype none

`include "hex_record_memory_loader_assert.svh"

module hrml_parser import hrml_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire item_t   item,
  output result_t      result
);

  typedef enum logic [3:0] {
    PH_START, PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_SUM, PH_EOL, PH_DONE, PH_ERROR
  } phase_t;

  phase_t              phase, phase_next;
  logic                digit_parity, digit_parity_next;
  logic [3:0]          hi_nib, hi_nib_next;
  logic [7:0]          record_length, record_length_next;
  logic [AddrBits-1:0] record_address, record_address_next;
  logic [7:0]          addr_hi, addr_hi_next;
  logic                addr_byte, addr_byte_next;
  logic [7:0]          record_type, record_type_next;
  logic [7:0]          bytes_remaining, bytes_remaining_next;

  logic [7:0] digit;
  logic [7:0] bval;
  logic [7:0] remaining_dec;

  assign digit         = digit_value(item.character);
  assign bval          = {hi_nib, 4'b0000} | digit;
  assign remaining_dec = bytes_remaining - 8'd1;

  always_comb begin
    phase_next           = phase;
    digit_parity_next    = digit_parity;
    hi_nib_next          = hi_nib;
    record_length_next   = record_length;
    record_address_next  = record_address;
    addr_hi_next         = addr_hi;
    addr_byte_next       = addr_byte;
    record_type_next     = record_type;
    bytes_remaining_next = bytes_remaining;
    result.write_valid   = 1'b0;
    result.write_address = '0;
    result.write_data    = '0;

    if (phase == PH_DONE || phase == PH_ERROR) begin
      // terminal: input ignored
    end else if (item.end_of_input) begin
      phase_next = PH_DONE;
    end else if (phase == PH_START) begin
      if (item.character == ColonChar) begin
        phase_next        = PH_LEN;
        digit_parity_next = 1'b0;
      end else begin
        phase_next = PH_ERROR;
      end
    end else if (phase == PH_EOL) begin
      if (item.character == LineFeed) begin
        phase_next = (record_type == EndRecord) ? PH_DONE : PH_START;
      end
    end else if (!digit_parity) begin
      hi_nib_next       = digit[3:0];
      digit_parity_next = 1'b1;
    end else begin
      digit_parity_next = 1'b0;
      case (phase)
        PH_LEN: begin
          record_length_next = bval;
          addr_byte_next     = 1'b0;
          phase_next         = PH_ADDR;
        end
        PH_ADDR: begin
          if (!addr_byte) begin
            addr_hi_next   = bval;
            addr_byte_next = 1'b1;
          end else begin
            record_address_next = AddrBits'({addr_hi, bval});
            addr_byte_next      = 1'b0;
            phase_next          = PH_TYPE;
          end
        end
        PH_TYPE: begin
          record_type_next     = bval;
          bytes_remaining_next = record_length;
          phase_next           = (record_length != 8'd0) ? PH_DATA : PH_SUM;
        end
        PH_DATA: begin
          if (record_type == DataRecord) begin
            result.write_valid   = 1'b1;
            result.write_address = 16'(record_address);
            result.write_data    = bval;
            record_address_next  = record_address + AddrBits'(1);
          end
          bytes_remaining_next = remaining_dec;
          if (remaining_dec == 8'd0) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_next = PH_EOL;
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end

    if (phase_next == PH_DONE) begin
      result.status = StatusDone;
    end else if (phase_next == PH_ERROR) begin
      result.status = StatusError;
    end else begin
      result.status = StatusLoading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      digit_parity    <= 1'b0;
      hi_nib          <= '0;
      record_length   <= '0;
      record_address  <= '0;
      addr_hi         <= '0;
      addr_byte       <= 1'b0;
      record_type     <= '0;
      bytes_remaining <= '0;
    end else if (en) begin
      phase           <= phase_next;
      digit_parity    <= digit_parity_next;
      hi_nib          <= hi_nib_next;
      record_length   <= record_length_next;
      record_address  <= record_address_next;
      addr_hi         <= addr_hi_next;
      addr_byte       <= addr_byte_next;
      record_type     <= record_type_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  `HRML_ASSERT(a_wr_loading, result.write_valid |-> result.status == StatusLoading, "late write")
  `HRML_ASSERT(a_done_sticks, (phase == PH_DONE) |=> (phase == PH_DONE), "finished load left done")
  `HRML_ASSERT(a_error_sticks, (phase == PH_ERROR) |=> (phase == PH_ERROR), "error state left")

endmodule

`default_nettype wire

// ----- rtl/hrml_out_buf.sv -----
// Two-entry result buffer between the parser and the output channel.
// Depends on hrml_pkg and the assertion macro header.
`default_nettype none

`include "hex_record_memory_loader_assert.svh"

module hrml_out_buf import hrml_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         valid,
  input  wire logic    stall,
  output result_t      data
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign pop   = valid && !stall;
  assign data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `HRML_ASSERT_ALWAYS(a_count_bound, rst || (count != 2'd3), "buffer count out of range")
  `HRML_ASSERT(a_no_overflow, push |-> !full, "push into full buffer")

endmodule

`default_nettype wire

// ----- rtl/hex_record_memory_loader.sv -----
// Hex record memory loader: one text character per transfer in, one write result out.
// Path from input transfer to result valid: input register, then result buffer.
// Throughput: one character per cycle while the result buffer has room.
// Reset (rst, synchronous, high): parser waits for a record start, buffers empty.
// Depends on hrml_pkg, hrml_parser, hrml_out_buf and the assertion macro header.
`default_nettype none

module hex_record_memory_loader import hrml_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  // character stream
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire item_t   in_data,
  // write results, one per character
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  // Input register stage.
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_fire;
  logic    in_xfer;
  logic    buf_full;
  result_t step_result;

  // The parser consumes the staged character whenever the result buffer has room.
  assign s1_fire  = s1_valid && !buf_full;
  // Stall only when a character is staged and cannot move on.
  assign in_stall = s1_valid && buf_full;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item <= in_data;
    end
  end

  // One parser step per staged character.
  hrml_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_fire),
    .item   (s1_item),
    .result (step_result)
  );

  // Result register plus one skid entry, so input keeps flowing while
  // a finished result waits for the consumer.
  hrml_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_fire),
    .push_data (step_result),
    .full      (buf_full),
    .valid     (out_valid),
    .stall     (out_stall),
    .data      (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/tb_hex_record_memory_loader.sv -----
// Testbench for hex_record_memory_loader: a character-level predictor in a scoreboard
// class, hex-record stimulus with random idling, and field-by-field result checks.
// Depends on hrml_pkg and the loader RTL.
`timescale 1ns / 1ps

import hrml_pkg::*;

// Tracks the parser state on accepted characters and holds the write results they imply.
class load_tracker;
  typedef enum logic [3:0] {
    AWAIT_COLON,
    GET_COUNT,
    GET_ADDR,
    GET_TYPE,
    GET_DATA,
    GET_SUM,
    SKIP_LINE,
    LOAD_DONE,
    LOAD_ERROR
  } parse_state_t;

  parse_state_t state;
  bit           low_next;
  logic [7:0]   high_nib;
  logic [7:0]   rec_len;
  logic [15:0]  rec_addr;
  logic [7:0]   rec_type;
  logic [7:0]   bytes_left;
  logic [1:0]   addr_bytes;
  result_t      expected_writes[$];
  int           errors;

  function new();
    state      = AWAIT_COLON;
    low_next   = 1'b0;
    high_nib   = '0;
    rec_len    = '0;
    rec_addr   = '0;
    rec_type   = '0;
    bytes_left = '0;
    addr_bytes = '0;
    errors     = 0;
  endfunction

  static function logic [7:0] digit_of(logic [7:0] c);
    logic [7:0] lc;
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    lc = c | CaseBit;
    if (lc >= 8'h61 && lc <= 8'h66) return lc - 8'h61 + 8'd10;
    return BadDigit;
  endfunction

  function void note_char(item_t it);
    result_t    r;
    logic [7:0] n;
    logic [7:0] b;
    r = '0;
    if (state == LOAD_DONE || state == LOAD_ERROR) begin
      // load is over, input ignored
    end else if (it.end_of_input) begin
      state = LOAD_DONE;
    end else if (state == AWAIT_COLON) begin
      if (it.character == ColonChar) begin
        state    = GET_COUNT;
        low_next = 1'b0;
      end else begin
        state = LOAD_ERROR;
      end
    end else if (state == SKIP_LINE) begin
      if (it.character == LineFeed) state = (rec_type == EndRecord) ? LOAD_DONE : AWAIT_COLON;
    end else begin
      n = digit_of(it.character);
      if (!low_next) begin
        high_nib = n;
        low_next = 1'b1;
      end else begin
        b        = {high_nib[3:0], 4'h0} | n;
        low_next = 1'b0;
        case (state)
          GET_COUNT: begin
            rec_len    = b;
            rec_addr   = '0;
            addr_bytes = '0;
            state      = GET_ADDR;
          end
          GET_ADDR: begin
            rec_addr   = {rec_addr[7:0], b};
            addr_bytes = addr_bytes + 2'd1;
            if (addr_bytes >= 2'd2) begin
              addr_bytes = '0;
              state      = GET_TYPE;
            end
          end
          GET_TYPE: begin
            rec_type   = b;
            bytes_left = rec_len;
            state      = (bytes_left != 0) ? GET_DATA : GET_SUM;
          end
          GET_DATA: begin
            if (rec_type == DataRecord) begin
              r.write_valid   = 1'b1;
              r.write_address = rec_addr;
              r.write_data    = b;
              rec_addr        = rec_addr + 16'd1;
            end
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 0) state = GET_SUM;
          end
          GET_SUM: state = SKIP_LINE;
          default: state = LOAD_ERROR;
        endcase
      end
    end
    if (state == LOAD_DONE) r.status = StatusDone;
    else if (state == LOAD_ERROR) r.status = StatusError;
    else r.status = StatusLoading;
    expected_writes.push_back(r);
  endfunction

  function void check_write(result_t got);
    result_t want;
    if (expected_writes.size() == 0) begin
      $error("result with nothing pending: %h", got);
      errors++;
      return;
    end
    want = expected_writes.pop_front();
    if (got.write_valid !== want.write_valid) begin
      $error("write_valid: expected %0d, got %0d", want.write_valid, got.write_valid);
      errors++;
    end
    if (got.write_address !== want.write_address) begin
      $error("write_address: expected %h, got %h", want.write_address, got.write_address);
      errors++;
    end
    if (got.write_data !== want.write_data) begin
      $error("write_data: expected %h, got %h", want.write_data, got.write_data);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      errors++;
    end
  endfunction

  function int outstanding();
    return expected_writes.size();
  endfunction
endclass

module tb_hex_record_memory_loader;

  localparam int         QuietLimit     = 4000;  // cycles with no transfer on either side
  localparam int         HoldCycles     = 400;   // long receiver hold-off
  localparam int         PhaseChars     = 475;   // characters per idling phase
  localparam int         TailCycles     = 8;     // margin after the last expected result
  localparam logic [7:0] CarriageReturn = 8'h0D;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  item_t   in_data;
  logic    out_valid;
  logic    out_stall;
  result_t out_data;

  load_tracker tracker;

  // Characters queued for the sender; records are built here, then drained.
  item_t   pending_chars[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int quiet_cycles = 0;

  hex_record_memory_loader uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Text building
  // ---------------------------------------------------------------------------

  function automatic void push_char(logic [7:0] c);
    item_t it;
    it.character    = c;
    it.end_of_input = 1'b0;
    pending_chars.push_back(it);
  endfunction

  // End-of-file marker; the character bits are don't-care, so randomize them.
  function automatic void push_eoi();
    item_t it;
    it.character    = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    pending_chars.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  // Any byte the decoder treats as a bad digit (counts as 0xFF).
  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (tracker.digit_of(c) != BadDigit) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Anything but a line feed; used as junk while the parser skips to the line end.
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CarriageReturn;
    c = 8'($urandom_range(0, 255));
    while (c == LineFeed) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    // mixed case, the decoder folds it
    if ($urandom_range(0, 1) == 1) return 8'h41 + v - 8'd10;
    return 8'h61 + v - 8'd10;
  endfunction

  // Two digits for one byte; each digit is garbage with odds 1 in bad_odds.
  function automatic void put_byte(logic [7:0] b, int bad_odds);
    if ($urandom_range(1, bad_odds) == 1) push_char(bad_char());
    else push_char(hex_char(b[7:4]));
    if ($urandom_range(1, bad_odds) == 1) push_char(bad_char());
    else push_char(hex_char(b[3:0]));
  endfunction

  function automatic void put_record(logic [7:0] len, logic [15:0] addr, logic [7:0] rtype,
                                     bit with_eol);
    push_char(ColonChar);
    put_byte(len, 200);  // a mangled count means a long record, keep it rare
    put_byte(addr[15:8], 40);
    put_byte(addr[7:0], 40);
    put_byte(rtype, 40);
    for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)), 40);
    put_byte(8'($urandom_range(0, 255)), 20);  // checksum is never checked
    if (with_eol) begin
      repeat ($urandom_range(0, 3)) push_char(junk_char());
      push_char(LineFeed);
    end
  endfunction

  // Record with random shape: mostly short data records, some other types,
  // a few long ones and a few close to the top of the address space.
  function automatic void random_record(bit with_eol);
    logic [7:0]  len;
    logic [15:0] addr;
    logic [7:0]  rtype;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) len = 8'($urandom_range(100, 255));
    else if (roll < 10) len = 8'd0;
    else len = 8'($urandom_range(1, 16));
    if ($urandom_range(0, 7) == 0) addr = 16'hFFF0 | 16'($urandom_range(0, 15));
    else addr = 16'($urandom_range(0, 65535));
    // type 1 would end the load, so it only shows up in the finale
    if ($urandom_range(0, 3) != 0) rtype = DataRecord;
    else rtype = 8'($urandom_range(2, 255));
    put_record(len, addr, rtype, with_eol);
  endfunction

  // End-of-file record (type 1) of random length; the load ends after its line feed.
  function automatic void random_put_end_record();
    put_record(8'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)), EndRecord, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transfer per queued character
  // ---------------------------------------------------------------------------

  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_char(it);
  endtask

  task automatic send_pending();
    item_t it;
    while (pending_chars.size() != 0) begin
      it = pending_chars.pop_front();
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: checks each result transfer, stalls at random or on a hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) tracker.check_write(out_data);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer anywhere means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_hex_record_memory_loader: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase_chars;
    int start;
    int cut;
    tracker        = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: count 2 at 0xFFFF so the second write wraps to 0x0000; mixed-case
    // digits; a bad digit in data and in the checksum; CR before LF.
    push_text(":02FFFF00aBg1/:\r\n");
    // Zero-length record of a non-data type, a ':' swallowed while skipping the line.
    push_text(":00cdef0209:\n");
    send_pending();

    // Long receiver hold-off while the sender keeps offering: the block fills and
    // must stall its input until the receiver lets go.
    hold_asked = hold_asked + 1;

    // Random records under four idling mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      phase_chars = 0;
      while (phase_chars < PhaseChars) begin
        random_record(1'b1);
        phase_chars += pending_chars.size();
        send_pending();
      end
    end

    // Finale: one way of ending the load, since every ending is final.
    case ($urandom_range(0, 4))
      0: random_put_end_record();
      1: push_eoi();                       // end of input at a record start
      2: begin                             // end of input inside a record
        start = pending_chars.size();
        random_record(1'b0);
        cut = $urandom_range(1, pending_chars.size() - start - 1);
        while (pending_chars.size() > start + cut) void'(pending_chars.pop_back());
        push_eoi();
      end
      3: begin                             // end of input while skipping to the line end
        random_record(1'b0);
        repeat ($urandom_range(0, 2)) push_char(junk_char());
        push_eoi();
      end
      default: begin                       // bad record start
        start = $urandom_range(0, 255);
        while (start == ColonChar) start = $urandom_range(0, 255);
        push_char(8'(start));
      end
    endcase
    // Everything after the end is ignored but still gets a result.
    repeat ($urandom_range(4, 8)) begin
      if ($urandom_range(0, 1) == 1) push_eoi();
      else push_char(8'($urandom_range(0, 255)));
    end
    send_pending();
    in_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("tb_hex_record_memory_loader: done, clean");
    end else begin
      $display("tb_hex_record_memory_loader: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hrml_pkg.sv
rtl/hrml_parser.sv
rtl/hrml_out_buf.sv
rtl/hex_record_memory_loader.sv
verif/tb_hex_record_memory_loader.sv
